FILE: hw/rtl/ordered_key_value_table_defines.svh
// assertion macros shared by the table checks
`ifndef ORDERED_KEY_VALUE_TABLE_DEFINES_SVH
`define ORDERED_KEY_VALUE_TABLE_DEFINES_SVH

// check that sleeps while reset is asserted
`define OKVT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also runs through reset
`define OKVT_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hw/rtl/okvt_pkg.sv
// types and constants of the ordered key/value table
package okvt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;

    localparam int KIND_BITS  = 3;
    localparam int POS_BITS   = 8;
    localparam int CAP_BITS   = 9;
    localparam int COUNT_BITS = 9;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = CNT_W + CAP_BITS + POS_BITS;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(256);

    localparam logic [KIND_BITS-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_UPDATE = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_UPSERT = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_ERASE  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_READ   = 3'd5;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [KEY_BITS-1:0]   search_key;
        logic [VALUE_BITS-1:0] new_value;
        logic [POS_BITS-1:0]   position;
    } t_req;

    typedef struct packed {
        logic                   ok;
        logic [KEY_BITS-1:0]    found_key;
        logic [VALUE_BITS-1:0]  found_value;
        logic [COUNT_BITS-1:0]  entry_count;
        logic                   table_empty;
    } t_rsp;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

endpackage

FILE: hw/rtl/ordered_key_value_table.sv
// ordered key/value table: packed insertion-order list in one synchronous memory
//
// Entries live in a single memory of key/value pairs with one write port and one
// registered read port. Insert, update, insert-or-update, erase and lookup scan the
// list from position 0, streaming one entry per cycle through the read port. Erase
// moves every later entry down one place through the same read and write ports
// while the scan streams on past the match, one entry per cycle. The next request
// is taken as soon as the previous result sits in the output register, even if the
// sink has not yet taken it. There is no clearing pass after reset: the entry count
// alone marks which positions hold data. The capacity register may be written at
// any time but is meant to change only while the table is idle.
module ordered_key_value_table
    import okvt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_req                i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_rsp                o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_BITS-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_POSRD  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [KIND_BITS-1:0]   r_kind, n_kind;
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [VALUE_BITS-1:0]  r_val, n_val;
    logic [CNT_W-1:0]       r_issue, n_issue;
    logic                   r_pend, n_pend;
    logic [CNT_W-1:0]       r_pend_ptr, n_pend_ptr;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CAP_BITS-1:0]    r_cap;
    logic                   r_res_ok, n_res_ok;
    logic [KEY_BITS-1:0]    r_res_key, n_res_key;
    logic [VALUE_BITS-1:0]  r_res_val, n_res_val;
    logic                   r_out_valid;
    t_rsp                   r_out;

    t_entry                 mem [TABLE_DEPTH];
    t_entry                 r_rd_data;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    t_entry                 wr_data;

    logic                   in_fire;
    logic                   out_free;
    logic                   hit;
    logic                   miss;
    logic                   room;
    logic                   pos_ok;
    logic                   last_pend;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign hit       = r_pend && (r_rd_data.key == r_key);
    assign miss      = !r_pend && (r_issue >= r_count);
    assign room      = (CMP_W'(r_count) < CMP_W'(r_cap))
                    && (CMP_W'(r_count) < CMP_W'(TABLE_DEPTH));
    assign pos_ok    = CMP_W'(i_in_data.position) < CMP_W'(r_count);
    assign last_pend = CNT_W'(r_pend_ptr + 1'b1) == r_count;

    // read port: position read at accept, else the streaming scan pointer
    always_comb begin
        rd_addr = r_issue[IDX_W-1:0];
        rd_en   = 1'b0;
        if (r_state == S_IDLE) begin
            rd_addr = IDX_W'(i_in_data.position);
            rd_en   = in_fire && (i_in_data.kind == KIND_READ) && pos_ok;
        end else if (r_state == S_SEARCH || r_state == S_SHIFT) begin
            rd_en = r_issue < r_count;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_key      = r_key;
        n_val      = r_val;
        n_issue    = rd_en ? CNT_W'(r_issue + 1'b1) : r_issue;
        n_pend     = rd_en;
        n_pend_ptr = r_issue;
        n_count    = r_count;
        n_res_ok   = r_res_ok;
        n_res_key  = r_res_key;
        n_res_val  = r_res_val;
        wr_en      = 1'b0;
        wr_addr    = r_pend_ptr[IDX_W-1:0];
        wr_data    = '{key: r_key, value: r_val};

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_kind    = i_in_data.kind;
                    n_key     = i_in_data.search_key;
                    n_val     = i_in_data.new_value;
                    n_issue   = '0;
                    n_res_ok  = 1'b0;
                    n_res_key = i_in_data.search_key;
                    n_res_val = '0;
                    unique case (i_in_data.kind)
                        KIND_INSERT, KIND_UPDATE, KIND_UPSERT,
                        KIND_ERASE, KIND_LOOKUP: begin
                            n_state = S_SEARCH;
                        end
                        KIND_READ: begin
                            n_state = pos_ok ? S_POSRD : S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                priority if (hit) begin
                    n_state = S_DONE;
                    unique case (r_kind)
                        KIND_UPDATE, KIND_UPSERT: begin
                            wr_en    = 1'b1;
                            n_res_ok = 1'b1;
                        end
                        KIND_ERASE: begin
                            n_res_ok = 1'b1;
                            // later entries pending: the scan becomes the shift
                            if (last_pend) begin
                                n_count = CNT_W'(r_count - 1'b1);
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                        KIND_LOOKUP: begin
                            n_res_ok  = 1'b1;
                            n_res_val = r_rd_data.value;
                        end
                        default: begin
                            n_res_ok = 1'b0;
                        end
                    endcase
                end else if (miss) begin
                    n_state = S_DONE;
                    if ((r_kind == KIND_INSERT || r_kind == KIND_UPSERT) && room) begin
                        wr_en    = 1'b1;
                        wr_addr  = r_count[IDX_W-1:0];
                        n_count  = CNT_W'(r_count + 1'b1);
                        n_res_ok = 1'b1;
                    end
                end else begin
                    // scan still streaming
                    n_state = S_SEARCH;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = IDX_W'(r_pend_ptr - 1'b1);
                    wr_data = r_rd_data;
                    if (last_pend) begin
                        n_count = CNT_W'(r_count - 1'b1);
                        n_state = S_DONE;
                    end
                end
            end
            S_POSRD: begin
                n_res_ok  = 1'b1;
                n_res_key = r_rd_data.key;
                n_res_val = r_rd_data.value;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_pend_ptr  <= '0;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issue    <= n_issue;
            r_pend     <= n_pend;
            r_pend_ptr <= n_pend_ptr;
            r_count    <= n_count;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_val     <= n_val;
        r_res_ok  <= n_res_ok;
        r_res_key <= n_res_key;
        r_res_val <= n_res_val;
        if (r_state == S_DONE && out_free) begin
            r_out.ok          <= r_res_ok;
            r_out.found_key   <= r_res_key;
            r_out.found_value <= r_res_val;
            r_out.entry_count <= COUNT_BITS'(r_count);
            r_out.table_empty <= (r_count == '0);
        end
    end

endmodule

FILE: hw/rtl/okvt_checker.sv
// port-level checks of the ordered key/value table, bound to the top level
`include "ordered_key_value_table_defines.svh"

module okvt_checker
    import okvt_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input t_rsp                o_out_data
);

    `OKVT_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result beat dropped")
    `OKVT_ASSERT_RST(a_rst_quiet, !i_rst_n |=> !o_out_valid, "result beat out of reset")
    `OKVT_ASSERT(a_busy_after_accept, i_in_valid && o_in_ready |=> !o_in_ready, "two requests overlap")
    `OKVT_ASSERT(a_empty_flag, o_out_valid |-> (o_out_data.table_empty == (o_out_data.entry_count == '0)), "empty flag disagrees with count")
    `OKVT_ASSERT(a_fail_no_value, o_out_valid && !o_out_data.ok |-> (o_out_data.found_value == '0), "value on failed request")

endmodule

bind ordered_key_value_table okvt_checker u_okvt_checker (.*);

FILE: test/tb_top.sv
// self-checking testbench for the ordered key/value table
`timescale 1ns / 1ps

module tb_top;
    import okvt_pkg::*;

    localparam logic [KIND_BITS-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_B = 3'd7;

    localparam int KEY_POOL_SIZE  = 16;
    localparam int STUCK_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 600;
    localparam int HOLDOFF_CYCLES = 400;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_req                i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_rsp                o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CAP_BITS-1:0] i_cfg_data  = '0;

    // shadow copy of the table, advanced once per accepted request
    logic [KEY_BITS-1:0]   tbl_keys   [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] tbl_values [TABLE_DEPTH];
    int                    tbl_count = 0;
    logic [CAP_BITS-1:0]   tbl_cap   = CAP_RESET;

    logic [KEY_BITS-1:0] key_pool [KEY_POOL_SIZE];

    t_rsp expected_rsps [$];
    int   err_count     = 0;
    int   stuck_cycles  = 0;
    int   src_max_wait  = 17;
    int   sink_max_wait = 17;
    int   sink_hold     = 0;

    ordered_key_value_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_wait(int max_w);
        return (max_w == 0) ? 0 : $urandom_range(0, max_w);
    endfunction

    function automatic int find_pos(logic [KEY_BITS-1:0] key);
        for (int p = 0; p < tbl_count; p++) begin
            if (tbl_keys[p] == key) return p;
        end
        return tbl_count;
    endfunction

    function automatic bit try_insert(logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value);
        int lim;
        lim = (int'(tbl_cap) < TABLE_DEPTH) ? int'(tbl_cap) : TABLE_DEPTH;
        if (tbl_count >= lim) return 1'b0;
        if (find_pos(key) < tbl_count) return 1'b0;
        tbl_keys[tbl_count]   = key;
        tbl_values[tbl_count] = value;
        tbl_count++;
        return 1'b1;
    endfunction

    function automatic bit try_update(logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value);
        int p;
        p = find_pos(key);
        if (p >= tbl_count) return 1'b0;
        tbl_values[p] = value;
        return 1'b1;
    endfunction

    function automatic t_rsp predict_rsp(t_req req);
        t_rsp rsp;
        int   p;
        rsp.ok          = 1'b0;
        rsp.found_key   = req.search_key;
        rsp.found_value = '0;
        case (req.kind)
            KIND_INSERT: rsp.ok = try_insert(req.search_key, req.new_value);
            KIND_UPDATE: rsp.ok = try_update(req.search_key, req.new_value);
            KIND_UPSERT: begin
                rsp.ok = try_insert(req.search_key, req.new_value);
                if (!rsp.ok) rsp.ok = try_update(req.search_key, req.new_value);
            end
            KIND_ERASE: begin
                p = find_pos(req.search_key);
                if (p < tbl_count) begin
                    // later entries slide down one place
                    for (int q = p; q + 1 < tbl_count; q++) begin
                        tbl_keys[q]   = tbl_keys[q + 1];
                        tbl_values[q] = tbl_values[q + 1];
                    end
                    tbl_count--;
                    rsp.ok = 1'b1;
                end
            end
            KIND_LOOKUP: begin
                p = find_pos(req.search_key);
                if (p < tbl_count) begin
                    rsp.ok          = 1'b1;
                    rsp.found_value = tbl_values[p];
                end
            end
            KIND_READ: begin
                if (int'(req.position) < tbl_count) begin
                    rsp.ok          = 1'b1;
                    rsp.found_key   = tbl_keys[req.position];
                    rsp.found_value = tbl_values[req.position];
                end
            end
            default: ;
        endcase
        rsp.entry_count = COUNT_BITS'(tbl_count);
        rsp.table_empty = (tbl_count == 0);
        return rsp;
    endfunction

    function automatic t_req mk_req(logic [KIND_BITS-1:0] kind, logic [KEY_BITS-1:0] key,
                                    logic [VALUE_BITS-1:0] value, logic [POS_BITS-1:0] pos);
        t_req req;
        req.kind       = kind;
        req.search_key = key;
        req.new_value  = value;
        req.position   = pos;
        return req;
    endfunction

    // grow_pct: inserts of fresh keys, shrink_pct: erases of stored keys
    function automatic t_req random_req(int grow_pct, int shrink_pct);
        t_req req;
        int   sel;
        int   key_sel;
        sel     = $urandom_range(0, 99);
        key_sel = $urandom_range(0, 99);
        req.new_value = $urandom();
        req.position  = (tbl_count > 0 && $urandom_range(0, 4) != 0) ?
                        POS_BITS'($urandom_range(0, tbl_count - 1)) :
                        POS_BITS'($urandom_range(0, 255));
        if (tbl_count > 0 && key_sel < 50)
            req.search_key = tbl_keys[$urandom_range(0, tbl_count - 1)];
        else if (key_sel < 85)
            req.search_key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        else
            req.search_key = $urandom();
        if (sel < grow_pct) begin
            req.kind       = $urandom_range(0, 1) ? KIND_INSERT : KIND_UPSERT;
            req.search_key = $urandom();
        end else if (sel < grow_pct + shrink_pct) begin
            req.kind = KIND_ERASE;
            if (tbl_count > 0) req.search_key = tbl_keys[$urandom_range(0, tbl_count - 1)];
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 15)      req.kind = KIND_INSERT;
            else if (sel < 30) req.kind = KIND_UPDATE;
            else if (sel < 45) req.kind = KIND_UPSERT;
            else if (sel < 62) req.kind = KIND_ERASE;
            else if (sel < 78) req.kind = KIND_LOOKUP;
            else if (sel < 96) req.kind = KIND_READ;
            else               req.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
        end
        return req;
    endfunction

    function automatic void refill_key_pool();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom();
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // valid stays high into the next item when its gap is zero
    task automatic send_req(input t_req req);
        int gap;
        gap = draw_wait(src_max_wait);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        expected_rsps.push_back(predict_rsp(req));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_rsps.size() != 0) @(posedge i_clk);
    endtask

    task automatic reconfigure_capacity(input logic [CAP_BITS-1:0] cap);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tbl_cap = cap;
    endtask

    // empty-table misses and spare kinds
    task automatic test_empty_table();
        send_req(mk_req(KIND_LOOKUP, 32'h0000_0000, 32'h1111_1111, 8'd0));
        send_req(mk_req(KIND_READ,   32'h0000_0000, 32'h0000_0000, 8'd0));
        send_req(mk_req(KIND_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255));
        send_req(mk_req(KIND_ERASE,  32'hFFFF_FFFF, 32'h0000_0000, 8'd0));
        send_req(mk_req(KIND_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 8'd0));
        send_req(mk_req(KIND_SPARE_A, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'hAA));
        send_req(mk_req(KIND_SPARE_B, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 8'h55));
    endtask

    task automatic test_basic_ops();
        send_req(mk_req(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 8'd0));
        send_req(mk_req(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0));
        send_req(mk_req(KIND_INSERT, 32'h0000_0000, 32'h0000_0001, 8'd0));
        send_req(mk_req(KIND_UPSERT, 32'h1234_5678, 32'h0000_0009, 8'd0));
        send_req(mk_req(KIND_UPSERT, 32'h0000_0000, 32'hAAAA_5555, 8'd0));
        send_req(mk_req(KIND_UPDATE, 32'hFFFF_FFFF, 32'hC0DE_0001, 8'd0));
        send_req(mk_req(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'd0));
        send_req(mk_req(KIND_READ,   32'h0000_0000, 32'h0000_0000, 8'd1));
        send_req(mk_req(KIND_READ,   32'h0000_0000, 32'h0000_0000, 8'd3));
        // erase at the head shifts the rest down
        send_req(mk_req(KIND_ERASE,  32'h0000_0000, 32'h0000_0000, 8'd0));
        send_req(mk_req(KIND_READ,   32'h0000_0000, 32'h0000_0000, 8'd0));
        send_req(mk_req(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'd0));
    endtask

    task automatic test_capacity_limits();
        reconfigure_capacity(9'd2);
        send_req(mk_req(KIND_INSERT, 32'h0000_0077, 32'h0000_0001, 8'd0));
        // full table, present key: upsert falls back to update
        send_req(mk_req(KIND_UPSERT, 32'h1234_5678, 32'h0BAD_F00D, 8'd0));
        send_req(mk_req(KIND_UPSERT, 32'h0000_0066, 32'h0000_0001, 8'd0));
        // limit below the count keeps the entries
        reconfigure_capacity(9'd0);
        send_req(mk_req(KIND_INSERT, 32'h0000_0066, 32'h0000_0002, 8'd0));
        send_req(mk_req(KIND_LOOKUP, 32'h1234_5678, 32'h0000_0000, 8'd0));
        send_req(mk_req(KIND_ERASE,  32'hFFFF_FFFF, 32'h0000_0000, 8'd0));
        send_req(mk_req(KIND_INSERT, 32'h0000_0088, 32'h0000_0003, 8'd0));
        reconfigure_capacity(9'd1);
        send_req(mk_req(KIND_INSERT, 32'h0000_0088, 32'h0000_0004, 8'd0));
        send_req(mk_req(KIND_ERASE,  32'h1234_5678, 32'h0000_0000, 8'd0));
        send_req(mk_req(KIND_INSERT, 32'h0000_0088, 32'h0000_0005, 8'd0));
        reconfigure_capacity(9'h1FF);
        send_req(mk_req(KIND_INSERT, 32'h0000_0099, 32'h0000_0006, 8'd0));
        send_req(mk_req(KIND_READ,   32'h0000_0000, 32'h0000_0000, 8'd1));
    endtask

    task automatic test_random_small();
        int caps [6];
        caps = '{1, 3, 8, 16, 0, 5};
        for (int c = 0; c < 6; c++) begin
            reconfigure_capacity(CAP_BITS'(caps[c]));
            refill_key_pool();
            src_max_wait  = (c % 2 == 0) ? 17 : 0;
            sink_max_wait = (c % 3 == 0) ? 0 : 17;
            repeat (60) send_req(random_req(20, 10));
        end
        src_max_wait  = 17;
        sink_max_wait = 17;
    endtask

    task automatic test_fill_to_depth();
        reconfigure_capacity(9'd256);
        refill_key_pool();
        while (tbl_count < TABLE_DEPTH) send_req(random_req(85, 0));
        send_req(mk_req(KIND_READ, 32'h0000_0000, 32'h0000_0000, 8'd255));
        repeat (20) send_req(random_req(30, 0));
        // limit above the built depth still stops at the depth
        reconfigure_capacity(9'h1FF);
        send_req(mk_req(KIND_INSERT, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 8'd0));
        repeat (20) send_req(random_req(30, 0));
        while (tbl_count > 8) send_req(random_req(5, 60));
    endtask

    task automatic test_sink_holdoff();
        reconfigure_capacity(9'd32);
        refill_key_pool();
        src_max_wait = 0;
        sink_hold    = HOLDOFF_CYCLES;
        repeat (50) send_req(random_req(20, 10));
        src_max_wait = 17;
    endtask

    task automatic test_sender_pause();
        logic [CAP_BITS-1:0] caps [3];
        caps = '{9'd4, 9'd256, 9'd2};
        for (int b = 0; b < 3; b++) begin
            reconfigure_capacity(caps[b]);
            refill_key_pool();
            repeat (40) send_req(random_req(20, 10));
        end
    endtask

    initial begin : run_tests
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_basic_ops();
        test_capacity_limits();
        test_random_small();
        test_fill_to_depth();
        test_sink_holdoff();
        test_sender_pause();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ordered_key_value_table regression: pass");
        end else begin
            $display("ordered_key_value_table regression: fail");
        end
        $finish;
    end

    // sink ready: random stall per result beat, or a long hold when asked
    initial begin : result_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (sink_hold) @(posedge i_clk);
                sink_hold = 0;
            end else begin
                stall = draw_wait(sink_max_wait);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid && sink_hold == 0);
        end
    end

    always @(posedge i_clk) begin : result_checker
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %0h", $time, o_out_data);
                err_count++;
            end else begin
                want = expected_rsps.pop_front();
                check_field("ok",          32'(want.ok),          32'(o_out_data.ok));
                check_field("found_key",   want.found_key,        o_out_data.found_key);
                check_field("found_value", want.found_value,      o_out_data.found_value);
                check_field("entry_count", 32'(want.entry_count), 32'(o_out_data.entry_count));
                check_field("table_empty", 32'(want.table_empty), 32'(o_out_data.table_empty));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("ordered_key_value_table regression: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
